// ===== rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Shared constants and types of the binary threshold closing unit.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int ROW_MAX       = 4095;
  localparam int ROW_W         = 13;
  localparam int PIX_W         = 8;
  localparam int DIM_W         = 12;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;
  localparam int LINE_W        = 2;

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd170;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

  typedef struct packed {
    logic bin;
    logic ring_d;
    logic dil_act;
    logic ring_e;
    logic ero_act;
    logic last;
  } ctrl_t;

endpackage

// ===== rtl/binary_threshold_closing_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// binary_threshold_closing_3x3_unit
// Streaming binary threshold followed by a 3x3 closing over line memories.
// ----------------------------------------------------------------------------
// The unit takes one grey pixel per clock in raster order and returns one
// binary result per item, 2*width+2 items behind the pixel it belongs to, so
// the frame is followed by 2*width+2 flush items to drain it; frame_last marks
// the final result. Each item passes through the line memory read (one
// port per memory, registered read) and then the window stage. The input
// stalls while the skid register is full, or while the output register is held
// by a stalled consumer and an item sits in the window stage.
// Width and height are taken when a frame's first pixel arrives; the line
// memories need no clearing after reset.
module binary_threshold_closing_3x3_unit import btc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_flush,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_closed_pixel,
  output logic              out_frame_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] threshold;
  logic [DIM_W-1:0] image_width, image_height;
  logic             accept, rd_en, s1_valid, skid_valid;
  logic [CW-1:0]    rd_bin_addr, rd_dil_addr, s1_bin_addr, s1_dil_addr;
  ctrl_t            s1_ctrl;
  logic             res_valid, res_pixel, res_last;

  assign in_stall = skid_valid || (out_valid && s1_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  btc_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .threshold    (threshold),
    .image_width  (image_width),
    .image_height (image_height)
  );

  btc_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .flush        (in_flush),
    .pixel_value  (in_pixel_value),
    .threshold    (threshold),
    .image_width  (image_width),
    .image_height (image_height),
    .rd_en        (rd_en),
    .rd_bin_addr  (rd_bin_addr),
    .rd_dil_addr  (rd_dil_addr),
    .s1_valid     (s1_valid),
    .s1_ctrl      (s1_ctrl),
    .s1_bin_addr  (s1_bin_addr),
    .s1_dil_addr  (s1_dil_addr)
  );

  btc_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (rd_en),
    .rd_bin_addr (rd_bin_addr),
    .rd_dil_addr (rd_dil_addr),
    .s1_valid    (s1_valid),
    .s1_ctrl     (s1_ctrl),
    .s1_bin_addr (s1_bin_addr),
    .s1_dil_addr (s1_dil_addr),
    .res_valid   (res_valid),
    .res_pixel   (res_pixel),
    .res_last    (res_last)
  );

  btc_out_buf u_obuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (res_valid),
    .push_pixel       (res_pixel),
    .push_last        (res_last),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_closed_pixel (out_closed_pixel),
    .out_frame_last   (out_frame_last),
    .skid_valid       (skid_valid)
  );

endmodule

// ===== rtl/btc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// btc_cfg_regs
// APB register bank holding the threshold and the frame dimensions.
// ----------------------------------------------------------------------------
module btc_cfg_regs import btc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [PIX_W-1:0]  threshold,
  output logic [DIM_W-1:0]  image_width,
  output logic [DIM_W-1:0]  image_height
);

  logic [PIX_W-1:0] threshold_r;
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= RST_THRESHOLD;
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD:    threshold_r    <= pwdata[PIX_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD:    prdata = APB_DW'(threshold_r);
      REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_r);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_r);
      default:          prdata = '0;
    endcase
  end

  assign threshold    = threshold_r;
  assign image_width  = image_width_r;
  assign image_height = image_height_r;

endmodule

// ===== rtl/btc_line_mem.sv =====
// ----------------------------------------------------------------------------
// btc_line_mem
// Column-indexed line memory holding the two previous rows, with a
// registered read and forwarding of a write to the entry being read.
// ----------------------------------------------------------------------------
module btc_line_mem import btc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [LINE_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [LINE_W-1:0]        wr_data
);

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] q_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

endmodule

// ===== rtl/btc_seq.sv =====
// ----------------------------------------------------------------------------
// btc_seq
// Frame sequencer: tracks the input, dilation and erosion positions, sorts
// each item and issues the line memory reads.
// ----------------------------------------------------------------------------
module btc_seq import btc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         flush,
  input  logic [PIX_W-1:0]             pixel_value,
  input  logic [PIX_W-1:0]             threshold,
  input  logic [DIM_W-1:0]             image_width,
  input  logic [DIM_W-1:0]             image_height,
  output logic                         rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_bin_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_dil_addr,
  output logic                         s1_valid,
  output ctrl_t                        s1_ctrl,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_bin_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_dil_addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH * (ROW_MAX + 2) + 3);

  logic [PW-1:0]    p_r;
  logic [ROW_W-1:0] row_in_r, rd_r, re_r;
  logic [CW-1:0]    col_in_r, cd_r, ce_r;
  logic             dil_act_r, ero_act_r;
  logic [WW-1:0]    act_w_r;
  logic [DIM_W-1:0] act_h_r;
  logic             s1_valid_r;
  ctrl_t            s1_ctrl_r;
  logic [CW-1:0]    s1_bin_addr_r, s1_dil_addr_r;

  logic             idle, in_frame, process;
  logic [WW-1:0]    w_cfg, w_use, w_m1;
  logic [DIM_W-1:0] h_cfg, h_use, h_m1;
  logic [WW:0]      lag;
  logic [WW+1:0]    lag2;
  logic             d_act, e_act, last;
  logic             col_in_end, cd_end, ce_end;
  logic             ring_d, ring_e;
  ctrl_t            ctrl_nxt;

  always_comb begin
    if (int'(image_width) > MAX_WIDTH) begin
      w_cfg = WW'(MAX_WIDTH);
    end else if (image_width == '0) begin
      w_cfg = WW'(1);
    end else begin
      w_cfg = WW'(image_width);
    end
  end

  assign h_cfg    = (image_height == '0) ? DIM_W'(1) : image_height;
  assign idle     = (p_r == '0);
  assign w_use    = idle ? w_cfg : act_w_r;
  assign h_use    = idle ? h_cfg : act_h_r;
  assign w_m1     = w_use - WW'(1);
  assign h_m1     = h_use - DIM_W'(1);
  assign lag      = (WW+1)'(w_use) + (WW+1)'(1);
  assign lag2     = {lag, 1'b0};
  assign in_frame = idle || (row_in_r < ROW_W'(h_use));
  assign process  = accept && !(flush && in_frame);

  assign d_act = dil_act_r || (p_r == PW'(lag));
  assign e_act = ero_act_r || (p_r == PW'(lag2));

  assign col_in_end = (WW'(col_in_r) == w_m1);
  assign cd_end     = (WW'(cd_r) == w_m1);
  assign ce_end     = (WW'(ce_r) == w_m1);
  assign last       = e_act && ce_end && (re_r == ROW_W'(h_m1));

  assign ring_d = (rd_r == '0) || (cd_r == '0) || (rd_r >= ROW_W'(h_m1)) || cd_end;
  assign ring_e = (re_r == '0) || (ce_r == '0) || (re_r >= ROW_W'(h_m1)) || ce_end;

  always_comb begin
    ctrl_nxt.bin     = pixel_value > threshold;
    ctrl_nxt.ring_d  = ring_d;
    ctrl_nxt.dil_act = d_act;
    ctrl_nxt.ring_e  = ring_e;
    ctrl_nxt.ero_act = e_act;
    ctrl_nxt.last    = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r        <= '0;
      row_in_r   <= '0;
      col_in_r   <= '0;
      rd_r       <= '0;
      cd_r       <= '0;
      re_r       <= '0;
      ce_r       <= '0;
      dil_act_r  <= 1'b0;
      ero_act_r  <= 1'b0;
      act_w_r    <= '0;
      act_h_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= process;
      if (process) begin
        if (idle) begin
          act_w_r <= w_cfg;
          act_h_r <= h_cfg;
        end
        if (last) begin
          p_r       <= '0;
          row_in_r  <= '0;
          col_in_r  <= '0;
          rd_r      <= '0;
          cd_r      <= '0;
          re_r      <= '0;
          ce_r      <= '0;
          dil_act_r <= 1'b0;
          ero_act_r <= 1'b0;
        end else begin
          p_r <= p_r + PW'(1);
          if (col_in_end) begin
            col_in_r <= '0;
            row_in_r <= row_in_r + ROW_W'(1);
          end else begin
            col_in_r <= col_in_r + CW'(1);
          end
          if (d_act) begin
            dil_act_r <= 1'b1;
            if (cd_end) begin
              cd_r <= '0;
              rd_r <= rd_r + ROW_W'(1);
            end else begin
              cd_r <= cd_r + CW'(1);
            end
          end
          if (e_act) begin
            ero_act_r <= 1'b1;
            if (ce_end) begin
              ce_r <= '0;
              re_r <= re_r + ROW_W'(1);
            end else begin
              ce_r <= ce_r + CW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      s1_ctrl_r     <= ctrl_nxt;
      s1_bin_addr_r <= col_in_r;
      s1_dil_addr_r <= cd_r;
    end
  end

  assign rd_en       = process;
  assign rd_bin_addr = col_in_r;
  assign rd_dil_addr = cd_r;
  assign s1_valid    = s1_valid_r;
  assign s1_ctrl     = s1_ctrl_r;
  assign s1_bin_addr = s1_bin_addr_r;
  assign s1_dil_addr = s1_dil_addr_r;

endmodule

// ===== rtl/btc_datapath.sv =====
// ----------------------------------------------------------------------------
// btc_datapath
// Window stage: combines the line memory columns with the held window
// columns, forms the dilation and the erosion and writes the rows back.
// ----------------------------------------------------------------------------
module btc_datapath import btc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_bin_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_dil_addr,
  input  logic                         s1_valid,
  input  ctrl_t                        s1_ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_bin_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_dil_addr,
  output logic                         res_valid,
  output logic                         res_pixel,
  output logic                         res_last
);

  logic [LINE_W-1:0] bin_q, dil_q;
  logic [LINE_W-1:0] bin_wr_data, dil_wr_data;
  logic              dil_wr_en;
  logic [2:0]        bin_col, dil_col;
  logic [5:0]        bwin_r, dwin_r;
  logic              dil_px, ero_px;

  // Each memory word holds the previous row in bit 1 and the row before it in bit 0.
  btc_line_mem #(.DEPTH(MAX_WIDTH)) u_bin_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_bin_addr),
    .rd_data (bin_q),
    .wr_en   (s1_valid),
    .wr_addr (s1_bin_addr),
    .wr_data (bin_wr_data)
  );

  btc_line_mem #(.DEPTH(MAX_WIDTH)) u_dil_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_dil_addr),
    .rd_data (dil_q),
    .wr_en   (dil_wr_en),
    .wr_addr (s1_dil_addr),
    .wr_data (dil_wr_data)
  );

  assign bin_col     = {bin_q, s1_ctrl.bin};
  assign bin_wr_data = {s1_ctrl.bin, bin_q[1]};
  assign dil_px      = !s1_ctrl.ring_d && (|{bwin_r, bin_col});

  assign dil_wr_en   = s1_valid && s1_ctrl.dil_act;
  assign dil_col     = {dil_q, dil_px};
  assign dil_wr_data = {dil_px, dil_q[1]};
  assign ero_px      = !s1_ctrl.ring_e && (&{dwin_r, dil_col});

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      bwin_r <= {bwin_r[2:0], bin_col};
    end
    if (dil_wr_en) begin
      dwin_r <= {dwin_r[2:0], dil_col};
    end
  end

  assign res_valid = s1_valid && s1_ctrl.ero_act;
  assign res_pixel = ero_px;
  assign res_last  = s1_ctrl.last;

endmodule

// ===== rtl/btc_out_buf.sv =====
// ----------------------------------------------------------------------------
// btc_out_buf
// Two-entry output buffer: an output register and a skid register.
// ----------------------------------------------------------------------------
module btc_out_buf import btc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_pixel,
  input  logic push_last,
  input  logic out_stall,
  output logic out_valid,
  output logic out_closed_pixel,
  output logic out_frame_last,
  output logic skid_valid
);

  logic out_valid_r, out_pix_r, out_last_r;
  logic skid_valid_r, skid_pix_r, skid_last_r;
  logic pop, head_free, skid_load;

  assign pop       = out_valid_r && !out_stall;
  assign head_free = !out_valid_r || pop;
  assign skid_load = push && (skid_valid_r ? head_free : !head_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid_r) begin
        out_pix_r  <= skid_pix_r;
        out_last_r <= skid_last_r;
      end else if (push) begin
        out_pix_r  <= push_pixel;
        out_last_r <= push_last;
      end
    end
    if (skid_load) begin
      skid_pix_r  <= push_pixel;
      skid_last_r <= push_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_closed_pixel = out_pix_r;
  assign out_frame_last   = out_last_r;
  assign skid_valid       = skid_valid_r;

endmodule

// ===== tb/sv/btc_closing_checker.sv =====
// ----------------------------------------------------------------------------
// btc_closing_checker
// Watches the pixel, result and register channels of the closing unit, keeps
// its own copy of the line stores and window positions, and compares every
// result item with the value it predicts.
// ----------------------------------------------------------------------------
module btc_closing_checker import btc_pkg::*; #(
  parameter int MAX_W = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_flush,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_closed_pixel,
  input  logic              out_frame_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatches,
  output int                results_owed,
  output int                results_seen,
  output int                foreground_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic closed_pixel;
    logic frame_last;
  } closed_pixel_t;

  closed_pixel_t     owed_pixels[$];
  closed_pixel_t     oldest;
  logic [PIX_W-1:0]  thr;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  bit                bin_rows [3*MAX_W];
  bit                dil_rows [3*MAX_W];
  int                frame_pos;
  int                act_w;
  int                act_h;
  int                fails;
  int                seen;
  int                fg;

  function automatic int slot(int row, int col);
    return (row % 3) * MAX_W + (col % MAX_W);
  endfunction

  function automatic bit on_ring(int r, int c);
    return r == 0 || c == 0 || r + 1 >= act_h || c + 1 >= act_w;
  endfunction

  function automatic bit window_any(int r, int c);
    for (int dr = 0; dr < 3; dr++)
      for (int dc = 0; dc < 3; dc++)
        if (bin_rows[slot(r + dr - 1, c + dc - 1)]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit window_all(int r, int c);
    for (int dr = 0; dr < 3; dr++)
      for (int dc = 0; dc < 3; dc++)
        if (!dil_rows[slot(r + dr - 1, c + dc - 1)]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic step_closing(input logic [PIX_W-1:0] pix, input logic fl);
    int total;
    int lag;
    int p;
    int q;
    int s;
    closed_pixel_t res;
    if (frame_pos == 0) begin
      if (fl) return;
      act_w = (width_r > MAX_W) ? MAX_W : int'(width_r);
      if (act_w == 0) act_w = 1;
      act_h = (height_r == 0) ? 1 : int'(height_r);
    end
    total = act_w * act_h;
    lag   = act_w + 1;
    p     = frame_pos;
    if (p < total) begin
      if (fl) return;
      bin_rows[slot(p / act_w, p % act_w)] = (pix > thr);
    end
    frame_pos = p + 1;
    if (p >= lag && p - lag < total) begin
      q = p - lag;
      dil_rows[slot(q / act_w, q % act_w)] =
        on_ring(q / act_w, q % act_w) ? 1'b0 : window_any(q / act_w, q % act_w);
    end
    if (p >= 2 * lag && p - 2 * lag < total) begin
      s = p - 2 * lag;
      res.closed_pixel =
        on_ring(s / act_w, s % act_w) ? 1'b0 : window_all(s / act_w, s % act_w);
      res.frame_last = (s + 1 == total);
      owed_pixels.push_back(res);
      if (res.frame_last) frame_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr       = RST_THRESHOLD;
      width_r   = RST_IMAGE_WIDTH;
      height_r  = RST_IMAGE_HEIGHT;
      bin_rows  = '{default: 1'b0};
      dil_rows  = '{default: 1'b0};
      frame_pos = 0;
      act_w     = 0;
      act_h     = 0;
      fails     = 0;
      seen      = 0;
      fg        = 0;
      owed_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (out_closed_pixel === 1'b1) fg++;
        if (owed_pixels.size() == 0) begin
          $error("result with nothing owed: closed_pixel %0b frame_last %0b",
                 out_closed_pixel, out_frame_last);
          fails++;
        end else begin
          oldest = owed_pixels.pop_front();
          if (out_closed_pixel !== oldest.closed_pixel) begin
            $error("closed_pixel: expected %0b, got %0b",
                   oldest.closed_pixel, out_closed_pixel);
            fails++;
          end
          if (out_frame_last !== oldest.frame_last) begin
            $error("frame_last: expected %0b, got %0b",
                   oldest.frame_last, out_frame_last);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) step_closing(in_pixel_value, in_flush);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESHOLD:    thr      = pwdata[PIX_W-1:0];
          REG_IMAGE_WIDTH:  width_r  = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_r = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches      <= fails;
    results_owed    <= owed_pixels.size();
    results_seen    <= seen;
    foreground_seen <= fg;
  end

endmodule

// ===== tb/sv/tb_binary_threshold_closing_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// tb_binary_threshold_closing_3x3_unit
// Streams grey frames through the closing unit under random gaps and stalls.
// ----------------------------------------------------------------------------
// A short directed part fills a hole in a 5x5 frame and tries ignored and
// misplaced flush items, tiny frames and the threshold extremes. Random small
// frames with noise follow, then one frame with neither gaps nor stalls.
// The checker beside the block predicts and compares every result item.
module tb_binary_threshold_closing_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import btc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 450;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_value = '0;
  logic              in_flush       = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_closed_pixel;
  logic              out_frame_last;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [APB_AW-1:0] paddr          = '0;
  logic [APB_DW-1:0] pwdata         = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                results_owed;
  int                results_seen;
  int                foreground_seen;
  int                cycle_count    = 0;
  int                items_sent     = 0;
  int                frames_run     = 0;
  int                frame_w;
  int                frame_h;
  logic [PIX_W-1:0]  cur_thr;
  bit                idle_on        = 1'b1;

  logic [PIX_W-1:0]  hole_frame [25] = '{
    8'd0,   8'd255, 8'd128, 8'd127, 8'd0,
    8'd0,   8'd200, 8'd128, 8'd255, 8'd85,
    8'd170, 8'd128, 8'd0,   8'd255, 8'd127,
    8'd255, 8'd128, 8'd255, 8'd130, 8'd0,
    8'd127, 8'd0,   8'd255, 8'd255, 8'd170
  };

  binary_threshold_closing_3x3_unit #(
    .MAX_WIDTH (DEF_MAX_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .in_flush         (in_flush),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_closed_pixel (out_closed_pixel),
    .out_frame_last   (out_frame_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  btc_closing_checker #(
    .MAX_W (DEF_MAX_WIDTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .in_flush         (in_flush),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_closed_pixel (out_closed_pixel),
    .out_frame_last   (out_frame_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .results_owed     (results_owed),
    .results_seen     (results_seen),
    .foreground_seen  (foreground_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** binary_threshold_closing_3x3_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    int v;
    case ($urandom_range(3))
      0:       v = cur_thr;
      1:       v = (cur_thr == 8'd255) ? 255 : cur_thr + 1;
      default: v = $urandom_range(255);
    endcase
    return v[PIX_W-1:0];
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_flush       <= fl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs(input logic [PIX_W-1:0] thr, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h);
    logic [1:0]        idx  [3] = '{REG_THRESHOLD, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    logic [APB_DW-1:0] vals [3];
    vals = '{APB_DW'(thr), APB_DW'(w), APB_DW'(h)};
    settle(SETTLE_CYCLES);
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_thr = thr;
    frame_w = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : ((w == 0) ? 1 : int'(w));
    frame_h = (h == 0) ? 1 : int'(h);
  endtask

  task automatic drain_frame(input bit noisy, input bit pause);
    for (int k = 0; k < 2 * frame_w + 2; k++) begin
      if (pause && k == frame_w + 1) settle(0);
      if (noisy && (k == 0 || $urandom_range(99) < 10)) send_item(8'($urandom), 1'b0);
      else send_item(8'($urandom), 1'b1);
      items_sent++;
    end
    frames_run++;
  endtask

  task automatic run_frame(input bit noisy);
    for (int p = 0; p < frame_w * frame_h; p++) begin
      if (noisy && $urandom_range(99) < 3) send_item(8'($urandom), 1'b1);
      send_item(pick_pixel(), 1'b0);
      items_sent++;
    end
    drain_frame(noisy, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    program_regs(8'd127, 12'd5, 12'd5);
    for (int p = 0; p < 25; p++) begin
      if (p == 12) send_item(8'hAA, 1'b1);
      send_item(hole_frame[p], 1'b0);
      items_sent++;
    end
    drain_frame(1'b1, 1'b1);
    program_regs(8'd0, 12'd3, 12'd4);
    run_frame(1'b0);
    program_regs(8'd90, 12'd0, 12'd0);
    run_frame(1'b0);
    program_regs(8'd255, 12'd5, 12'd5);
    run_frame(1'b0);
    program_regs(8'd0, 12'd5, 12'd5);
    run_frame(1'b0);

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       cur_thr = 8'd0;
        1:       cur_thr = 8'd255;
        default: cur_thr = 8'($urandom_range(255));
      endcase
      program_regs(cur_thr, 12'($urandom_range(5, 12)), 12'($urandom_range(5, 9)));
      run_frame(1'b1);
      if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b1);
    end

    program_regs(8'd128, 12'd12, 12'd9);
    idle_on = 1'b0;
    run_frame(1'b1);
    idle_on = 1'b1;

    settle(4 * SETTLE_CYCLES);
    $display("Sent %0d items over %0d frames, widths 1 to 12 and heights 1 to 9.",
             items_sent, frames_run);
    $display("Checked %0d result items, %0d of them foreground.",
             results_seen, foreground_seen);
    if (mismatches == 0 && results_owed == 0) begin
      $display("** binary_threshold_closing_3x3_unit: PASSED **");
    end else begin
      $display("** binary_threshold_closing_3x3_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== binary_threshold_closing_3x3_unit.f =====
rtl/btc_pkg.sv
rtl/btc_cfg_regs.sv
rtl/btc_line_mem.sv
rtl/btc_seq.sv
rtl/btc_datapath.sv
rtl/btc_out_buf.sv
rtl/binary_threshold_closing_3x3_unit.sv
tb/sv/btc_closing_checker.sv
tb/sv/tb_binary_threshold_closing_3x3_unit.sv
